/* rtl/core/pvae_pkg.sv */
// Shared types and constants of the position, velocity and acceleration estimator.
`default_nettype none
package pvae_pkg;
    localparam int DATA_W  = 32;
    localparam int TIME_W  = 40;
    localparam int CFG_W   = 4;
    localparam int NUM_W   = 54;
    localparam int US_PER_S = 1000000;
    localparam int WIN_RESET = 5;

    localparam logic REG_POS_WIN = 1'b0;
    localparam logic REG_VEL_WIN = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef struct packed {
        logic sample;
        logic tick;
        logic clr_pos;
        logic clr_vel;
        logic rate_ok;
    } t_lane_cmd;

    typedef struct packed {
        logic done;
        logic pos_empty;
    } t_lane_stat;
endpackage
`default_nettype wire

/* rtl/core/pvae_if.sv */
// Valid/ready channel interfaces for sample/tick input and estimate output.
`default_nettype none
interface pvae_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] pos_in_x;
    logic signed [31:0] pos_in_y;
    logic signed [31:0] pos_in_z;
    logic [39:0]        tick_time_us;

    modport source (output valid, kind, pos_in_x, pos_in_y, pos_in_z, tick_time_us,
                    input ready);
    modport sink   (input valid, kind, pos_in_x, pos_in_y, pos_in_z, tick_time_us,
                    output ready);
endinterface

interface pvae_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] avg_pos_x;
    logic signed [31:0] avg_pos_y;
    logic signed [31:0] avg_pos_z;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic               rates_valid;

    modport source (output valid, avg_pos_x, avg_pos_y, avg_pos_z, speed_x, speed_y,
                    speed_z, accel_x, accel_y, accel_z, rates_valid, input ready);
    modport sink   (input valid, avg_pos_x, avg_pos_y, avg_pos_z, speed_x, speed_y,
                    speed_z, accel_x, accel_y, accel_z, rates_valid, output ready);
endinterface
`default_nettype wire

/* rtl/core/pvae_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module pvae_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 40
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quo
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= STEP_W'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

/* rtl/core/pvae_lane.sv */
// One axis lane: position and velocity histories, window averages and rates.
`default_nettype none
module pvae_lane #(
    parameter int MAX_WINDOW = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pvae_pkg::t_lane_cmd                i_cmd,
    input  wire logic signed [pvae_pkg::DATA_W-1:0] i_sample,
    input  wire logic [pvae_pkg::TIME_W-1:0]        i_elapsed,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]    i_pos_win,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]    i_vel_win,
    output pvae_pkg::t_lane_stat                    o_stat,
    output logic signed [pvae_pkg::DATA_W-1:0]      o_avg,
    output logic signed [pvae_pkg::DATA_W-1:0]      o_vel,
    output logic signed [pvae_pkg::DATA_W-1:0]      o_acc
);
    import pvae_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = DATA_W + CNT_W;
    localparam int MAG_W = DATA_W + 1;

    typedef enum logic [2:0] {
        L_IDLE, L_SUM, L_AVG, L_DIFF, L_MUL, L_RATE, L_PUSH, L_FIN
    } t_lstate;

    t_lstate r_state;
    logic    r_phase;

    logic signed [DATA_W-1:0] r_pos_mem [MAX_WINDOW];
    logic signed [DATA_W-1:0] r_vel_mem [MAX_WINDOW];
    logic signed [DATA_W-1:0] r_pos_rd;
    logic signed [DATA_W-1:0] r_vel_rd;

    logic [CNT_W-1:0] r_pfill, r_vfill;
    logic [IDX_W-1:0] r_phead, r_vhead;
    logic [CNT_W-1:0] r_cnt;
    logic             r_rd_vld;
    logic signed [SUM_W-1:0] r_sum;
    logic             r_neg;
    logic [MAG_W-1:0] r_mag;
    logic             r_rate_ok;
    logic [TIME_W-1:0] r_el;

    logic             r_div_start;
    logic [NUM_W-1:0] r_div_num;
    logic [TIME_W-1:0] r_div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    logic signed [DATA_W-1:0] r_avg, r_avel, r_vel, r_acc;
    logic signed [DATA_W-1:0] r_prev_pos, r_prev_vel;
    logic             r_done;

    logic [IDX_W-1:0] pos_wa, vel_wa, n_phead, n_vhead, rd_addr;
    logic [CNT_W-1:0] pos_h1, vel_h1, lim;
    logic             pos_we, vel_we;
    logic signed [DATA_W-1:0] rd_data, quo_s, cur, prev, sat;
    logic [SUM_W-1:0] sum_mag;
    logic signed [MAG_W:0] diff;

    always_comb begin
        pos_wa  = (CNT_W'(r_phead) >= i_pos_win) ? '0 : r_phead;
        pos_h1  = CNT_W'(pos_wa) + 1'b1;
        n_phead = (pos_h1 >= i_pos_win) ? '0 : pos_h1[IDX_W-1:0];
        vel_wa  = (CNT_W'(r_vhead) >= i_vel_win) ? '0 : r_vhead;
        vel_h1  = CNT_W'(vel_wa) + 1'b1;
        n_vhead = (vel_h1 >= i_vel_win) ? '0 : vel_h1[IDX_W-1:0];
        pos_we  = (r_state == L_IDLE) && i_cmd.sample;
        vel_we  = (r_state == L_PUSH);
        rd_addr = r_cnt[IDX_W-1:0];
        lim     = r_phase ? r_vfill : r_pfill;
        rd_data = r_phase ? r_vel_rd : r_pos_rd;
        sum_mag = (r_sum < 0) ? $unsigned(-r_sum) : $unsigned(r_sum);
        quo_s   = r_neg ? -$signed(div_quo[DATA_W-1:0]) : $signed(div_quo[DATA_W-1:0]);
        cur     = r_phase ? r_avel : r_avg;
        prev    = r_phase ? r_prev_vel : r_prev_pos;
        diff    = (MAG_W+1)'(cur) - (MAG_W+1)'(prev);
        if (r_neg) begin
            sat = (|div_quo[NUM_W-1:DATA_W-1]) ? {1'b1, {(DATA_W-1){1'b0}}}
                                                 : -$signed(div_quo[DATA_W-1:0]);
        end else begin
            sat = (|div_quo[NUM_W-1:DATA_W-1]) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                 : $signed(div_quo[DATA_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[pos_wa] <= i_sample;
        end
        if (vel_we) begin
            r_vel_mem[vel_wa] <= r_vel;
        end
        r_pos_rd <= r_pos_mem[rd_addr];
        r_vel_rd <= r_vel_mem[rd_addr];
    end

    pvae_div #(
        .NUM_W (NUM_W),
        .DEN_W (TIME_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= L_IDLE;
            r_phase     <= 1'b0;
            r_pfill     <= '0;
            r_vfill     <= '0;
            r_phead     <= '0;
            r_vhead     <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_div_start <= 1'b0;
            r_prev_pos  <= '0;
            r_prev_vel  <= '0;
            r_done      <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
            if (i_cmd.clr_pos) begin
                r_pfill <= '0;
                r_phead <= '0;
            end
            if (i_cmd.clr_vel) begin
                r_vfill <= '0;
                r_vhead <= '0;
            end
            case (r_state)
                L_IDLE: begin
                    if (i_cmd.sample) begin
                        r_phead <= n_phead;
                        if (r_pfill < i_pos_win) begin
                            r_pfill <= r_pfill + 1'b1;
                        end
                    end else if (i_cmd.tick) begin
                        r_rate_ok <= i_cmd.rate_ok;
                        r_el      <= i_elapsed;
                        r_phase   <= 1'b0;
                        r_cnt     <= '0;
                        r_rd_vld  <= 1'b0;
                        r_sum     <= '0;
                        r_state   <= L_SUM;
                    end
                end
                L_SUM: begin
                    if (r_rd_vld) begin
                        r_sum <= r_sum + SUM_W'(rd_data);
                    end
                    if (r_cnt < lim) begin
                        r_cnt    <= r_cnt + 1'b1;
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_neg       <= r_sum < 0;
                            r_div_num   <= NUM_W'(sum_mag);
                            r_div_den   <= TIME_W'(lim);
                            r_div_start <= 1'b1;
                            r_state     <= L_AVG;
                        end
                    end
                end
                L_AVG: begin
                    if (div_done) begin
                        if (r_phase) begin
                            r_avel <= quo_s;
                        end else begin
                            r_avg <= quo_s;
                        end
                        if (r_rate_ok) begin
                            r_state <= L_DIFF;
                        end else if (r_phase) begin
                            r_acc   <= '0;
                            r_state <= L_FIN;
                        end else begin
                            r_vel   <= '0;
                            r_state <= L_PUSH;
                        end
                    end
                end
                L_DIFF: begin
                    r_neg   <= diff[MAG_W];
                    r_mag   <= diff[MAG_W] ? MAG_W'(-diff) : MAG_W'(diff);
                    r_state <= L_MUL;
                end
                L_MUL: begin
                    r_div_num   <= NUM_W'(r_mag) * NUM_W'(US_PER_S);
                    r_div_den   <= r_el;
                    r_div_start <= 1'b1;
                    r_state     <= L_RATE;
                end
                L_RATE: begin
                    if (div_done) begin
                        if (r_phase) begin
                            r_acc   <= sat;
                            r_state <= L_FIN;
                        end else begin
                            r_vel   <= sat;
                            r_state <= L_PUSH;
                        end
                    end
                end
                L_PUSH: begin
                    r_vhead <= n_vhead;
                    if (r_vfill < i_vel_win) begin
                        r_vfill <= r_vfill + 1'b1;
                    end
                    r_phase  <= 1'b1;
                    r_cnt    <= '0;
                    r_rd_vld <= 1'b0;
                    r_sum    <= '0;
                    r_state  <= L_SUM;
                end
                L_FIN: begin
                    r_prev_pos <= r_avg;
                    r_prev_vel <= r_avel;
                    r_done     <= 1'b1;
                    r_state    <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.pos_empty = (r_pfill == '0);
    assign o_avg = r_avg;
    assign o_vel = r_vel;
    assign o_acc = r_acc;
endmodule
`default_nettype wire

/* rtl/core/position_velocity_accel_estimator.sv */
// Top level: APB window registers, input acceptance, three axis lanes and output merge.
//
// Input channel i_in carries transactions of two kinds. A position sample
// (kind 0) is written into every axis history in the cycle it is accepted.
// A tick (kind 1) with a microsecond timestamp makes one estimate transaction
// on o_est when at least one sample is held; with no sample held it is dropped.
// Three lanes, one per axis, work side by side; the merge stage registers their
// averaged position, velocity and acceleration as one output transaction.
// A tick with time advancing runs four 54-step divisions in turn on the per-lane
// bit-serial divider (position average, velocity, velocity average,
// acceleration). A tick with time not advancing skips both rate divisions.
// Back-to-back samples are accepted while the block is idle. Only one
// transaction is in work at a time.
// A finished estimate sits in the output register; while the receiver stalls
// the block goes on taking samples and the next tick, then holds that result
// internally and accepts nothing more.
// Synchronous reset sets both windows to 5 (or MAX_WINDOW if smaller), empties
// the histories and clears the previous values and the last tick time.
// Window registers are written over APB at byte addresses 0 and 4; a write
// empties that history.
`default_nettype none
module position_velocity_accel_estimator #(
    parameter int MAX_WINDOW = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pvae_in_if.sink          i_in,
    pvae_out_if.source       o_est,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pvae_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam logic [CNT_W-1:0] WIN_INIT =
        CNT_W'((WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET);

    typedef enum logic [1:0] {S_IDLE, S_BUSY, S_HOLD} t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_pos_win, r_vel_win;
    logic [TIME_W-1:0] r_last;
    logic              r_rate_ok;
    logic              r_out_valid;
    logic signed [DATA_W-1:0] r_avg [3];
    logic signed [DATA_W-1:0] r_vel [3];
    logic signed [DATA_W-1:0] r_acc [3];
    logic              r_rates_valid;

    logic              wr;
    logic [CNT_W-1:0]  wr_win;
    logic              accept, is_tick, tick_go, rate_ok, lanes_done, pos_empty, load;
    logic [TIME_W-1:0] elapsed;
    t_lane_cmd         cmd;
    t_lane_stat        stat [3];
    logic signed [DATA_W-1:0] lane_in  [3];
    logic signed [DATA_W-1:0] lane_avg [3];
    logic signed [DATA_W-1:0] lane_vel [3];
    logic signed [DATA_W-1:0] lane_acc [3];

    always_comb begin
        wr = psel && penable && pwrite;
        if (pwdata[CFG_W-1:0] == '0) begin
            wr_win = CNT_W'(1);
        end else if (int'(pwdata[CFG_W-1:0]) > MAX_WINDOW) begin
            wr_win = CNT_W'(MAX_WINDOW);
        end else begin
            wr_win = CNT_W'(pwdata[CFG_W-1:0]);
        end
        prdata = (paddr[2] == REG_VEL_WIN) ? 32'(r_vel_win) : 32'(r_pos_win);
    end

    assign pready = 1'b1;

    assign lane_in[0] = i_in.pos_in_x;
    assign lane_in[1] = i_in.pos_in_y;
    assign lane_in[2] = i_in.pos_in_z;

    always_comb begin
        accept     = i_in.valid && i_in.ready;
        is_tick    = (i_in.kind == KIND_TICK);
        pos_empty  = stat[0].pos_empty & stat[1].pos_empty & stat[2].pos_empty;
        lanes_done = stat[0].done & stat[1].done & stat[2].done;
        tick_go    = accept && is_tick && !pos_empty;
        rate_ok    = i_in.tick_time_us > r_last;
        elapsed    = i_in.tick_time_us - r_last;
        cmd.sample  = accept && (i_in.kind == KIND_SAMPLE);
        cmd.tick    = tick_go;
        cmd.rate_ok = rate_ok;
        cmd.clr_pos = wr && (paddr[2] == REG_POS_WIN);
        cmd.clr_vel = wr && (paddr[2] == REG_VEL_WIN);
        load        = (r_state == S_HOLD) && (!r_out_valid || o_est.ready);
    end

    assign i_in.ready = i_rst_n && (r_state == S_IDLE);

    for (genvar g = 0; g < 3; g++) begin : g_lane
        pvae_lane #(
            .MAX_WINDOW (MAX_WINDOW)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd),
            .i_sample  (lane_in[g]),
            .i_elapsed (elapsed),
            .i_pos_win (r_pos_win),
            .i_vel_win (r_vel_win),
            .o_stat    (stat[g]),
            .o_avg     (lane_avg[g]),
            .o_vel     (lane_vel[g]),
            .o_acc     (lane_acc[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos_win   <= WIN_INIT;
            r_vel_win   <= WIN_INIT;
            r_last      <= '0;
            r_rate_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr && (paddr[2] == REG_POS_WIN)) begin
                r_pos_win <= wr_win;
            end
            if (wr && (paddr[2] == REG_VEL_WIN)) begin
                r_vel_win <= wr_win;
            end
            if (r_out_valid && o_est.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (tick_go) begin
                        r_last    <= i_in.tick_time_us;
                        r_rate_ok <= rate_ok;
                        r_state   <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (lanes_done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_avg         <= lane_avg;
            r_vel         <= lane_vel;
            r_acc         <= lane_acc;
            r_rates_valid <= r_rate_ok;
        end
    end

    assign o_est.valid       = r_out_valid;
    assign o_est.avg_pos_x   = r_avg[0];
    assign o_est.avg_pos_y   = r_avg[1];
    assign o_est.avg_pos_z   = r_avg[2];
    assign o_est.speed_x     = r_vel[0];
    assign o_est.speed_y     = r_vel[1];
    assign o_est.speed_z     = r_vel[2];
    assign o_est.accel_x     = r_acc[0];
    assign o_est.accel_y     = r_acc[1];
    assign o_est.accel_z     = r_acc[2];
    assign o_est.rates_valid = r_rates_valid;
endmodule
`default_nettype wire
